// ----- rtl/ddd_pkg.sv -----
`default_nettype none

package ddd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TYPE  = 2'd2;

  // Element width codes (value_type[2:1]); value_type[0] set means unsigned
  localparam logic [1:0] TW_8  = 2'd0;
  localparam logic [1:0] TW_16 = 2'd1;
  localparam logic [1:0] TW_32 = 2'd2;
  localparam logic [1:0] TW_64 = 2'd3;

  // Reset values of the configuration registers
  localparam logic [6:0]  BIT_WIDTH_RST   = 7'd0;
  localparam logic [31:0] VALUE_COUNT_RST = 32'd1;
  localparam logic [2:0]  VALUE_TYPE_RST  = 3'd6;

  // Commands from controller to datapath
  typedef struct packed {
    logic emit_raw;
    logic emit_seed;
    logic load_word;
    logic extract;
    logic absorb;
    logic build;
    logic clear_partial;
  } ddd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic raw_mode;
    logic tile_full;
    logic seeds_in;
    logic code_ready;
    logic out_free;
  } ddd_stat_t;

  // Element width minus one
  function automatic logic [6:0] type_bits_m1(input logic [2:0] vt);
    logic [6:0] r;
    case (vt[2:1])
      TW_8:    r = 7'd7;
      TW_16:   r = 7'd15;
      TW_32:   r = 7'd31;
      default: r = 7'd63;
    endcase
    return r;
  endfunction

  // Truncate to the element type, then sign- or zero-extend to 64 bits
  function automatic logic [63:0] extend_value(input logic [63:0] v, input logic [2:0] vt);
    logic [63:0] r;
    case (vt[2:1])
      TW_8:    r = vt[0] ? {56'd0, v[7:0]}  : {{56{v[7]}}, v[7:0]};
      TW_16:   r = vt[0] ? {48'd0, v[15:0]} : {{48{v[15]}}, v[15:0]};
      TW_32:   r = vt[0] ? {32'd0, v[31:0]} : {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ddd_ctrl.sv -----
`default_nettype none

module ddd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  output logic                   in_stall,
  input  wire ddd_pkg::ddd_stat_t stat,
  output ddd_pkg::ddd_cmd_t      cmd
);
  import ddd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_EXTRACT = 3'b010,
    S_BUILD   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Take a transaction only when idle and the result register can load
  assign in_stall = !((state_r == S_IDLE) && stat.out_free);
  assign accept   = in_valid && !in_stall;

  // Sequence seeds, raw words and code words
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.raw_mode) begin
            cmd.emit_raw = !stat.tile_full;
          end else if (!stat.tile_full) begin
            if (!in_mode) begin
              cmd.emit_seed = !stat.seeds_in;
            end else if (stat.seeds_in) begin
              cmd.load_word = 1'b1;
              state_nxt     = S_EXTRACT;
            end
          end
        end
      end
      S_EXTRACT: begin
        if (stat.tile_full) begin
          cmd.clear_partial = 1'b1;
          state_nxt         = S_IDLE;
        end else if (stat.code_ready) begin
          cmd.extract = 1'b1;
          state_nxt   = S_BUILD;
        end else begin
          cmd.absorb = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_BUILD: begin
        if (stat.out_free) begin
          cmd.build = 1'b1;
          state_nxt = S_EXTRACT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ddd_datapath.sv -----
`default_nettype none

module ddd_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_write,
  input  wire logic [ddd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ddd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [63:0]                         in_word,
  input  wire ddd_pkg::ddd_cmd_t                   cmd,
  output ddd_pkg::ddd_stat_t                       stat,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic [63:0]                              out_value,
  output logic                                     out_last_in_item,
  output logic                                     out_tile_done
);
  import ddd_pkg::*;

  // Configuration
  logic [6:0]  bit_width_r;
  logic [31:0] value_count_r;
  logic [2:0]  value_type_r;

  // Tile state
  logic [63:0] older_r, newer_r;
  logic [63:0] pcode_r;        // open code bits, sign bit included
  logic [6:0]  pbits_r;        // bits of the open code gathered so far
  logic [31:0] emitted_r;
  logic [63:0] sh_r;           // unread bits of the word, left aligned
  logic [6:0]  rem_r;          // unread bit count
  logic        code_sign_r;
  logic [63:0] code_mag_r;

  // Result register
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_last_r;
  logic        out_done_r;

  logic [6:0]  tbm1, bw_eff, code_len, k;
  logic [34:0] bytes;
  logic [32:0] need;
  logic [31:0] emitted_inc;
  logic        raw_done, coded_done, raw_mode, out_free, load_out, build_last;
  logic        clear_stream;
  logic [63:0] full, mag_mask, absorbed, dd, built, seed_v;

  // Tile geometry and limits
  assign tbm1        = type_bits_m1(value_type_r);
  assign raw_mode    = bit_width_r >= tbm1;
  assign bw_eff      = (bit_width_r == 7'd0) ? 7'd1 : bit_width_r;
  assign code_len    = bw_eff + 7'd1;
  assign k           = code_len - pbits_r;
  assign bytes       = {3'd0, value_count_r} << value_type_r[2:1];
  assign need        = 33'(({1'b0, bytes} + 36'd7) >> 3);
  assign emitted_inc = emitted_r + 32'd1;
  assign raw_done    = {1'b0, emitted_inc} == need;
  assign coded_done  = emitted_inc == value_count_r;

  // Code extraction: finish the open code from the top of the word
  assign full     = (pcode_r << k) | (sh_r >> (7'd64 - k));
  assign mag_mask = (64'd1 << bw_eff) - 64'd1;
  assign absorbed = (pcode_r << rem_r) | (sh_r >> (7'd64 - rem_r));

  // Value rebuild
  assign dd         = code_sign_r ? (64'd0 - code_mag_r) : code_mag_r;
  assign built      = extend_value(dd + {newer_r[62:0], 1'b0} - older_r, value_type_r);
  assign seed_v     = extend_value(in_word, value_type_r);
  assign build_last = (rem_r < code_len) || coded_done;

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = cmd.emit_raw || cmd.emit_seed || cmd.build;

  always_comb begin
    stat.raw_mode   = raw_mode;
    stat.tile_full  = raw_mode ? ({1'b0, emitted_r} >= need) : (emitted_r >= value_count_r);
    stat.seeds_in   = emitted_r >= 32'd2;
    stat.code_ready = rem_r >= k;
    stat.out_free   = out_free;
  end

  // Any write to a known register starts a new tile
  always_comb begin
    case (cfg_index)
      CFG_BIT_WIDTH, CFG_VALUE_COUNT, CFG_VALUE_TYPE: clear_stream = cfg_write;
      default: clear_stream = 1'b0;
    endcase
  end

  // Control state and tile state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_width_r   <= BIT_WIDTH_RST;
      value_count_r <= VALUE_COUNT_RST;
      value_type_r  <= VALUE_TYPE_RST;
      older_r       <= '0;
      newer_r       <= '0;
      pcode_r       <= '0;
      pbits_r       <= '0;
      emitted_r     <= '0;
      rem_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BIT_WIDTH:   bit_width_r   <= cfg_data[6:0];
          CFG_VALUE_COUNT: value_count_r <= cfg_data;
          CFG_VALUE_TYPE:  value_type_r  <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (clear_stream) begin
        older_r   <= '0;
        newer_r   <= '0;
        pcode_r   <= '0;
        pbits_r   <= '0;
        emitted_r <= '0;
        rem_r     <= '0;
      end else begin
        if (cmd.emit_raw) begin
          emitted_r <= emitted_inc;
        end
        if (cmd.emit_seed) begin
          older_r   <= newer_r;
          newer_r   <= seed_v;
          emitted_r <= emitted_inc;
        end
        if (cmd.load_word) begin
          rem_r <= 7'd64;
        end
        if (cmd.extract) begin
          rem_r   <= rem_r - k;
          pcode_r <= '0;
          pbits_r <= '0;
        end
        if (cmd.absorb) begin
          pcode_r <= absorbed;
          pbits_r <= pbits_r + rem_r;
          rem_r   <= '0;
        end
        if (cmd.clear_partial) begin
          pcode_r <= '0;
          pbits_r <= '0;
          rem_r   <= '0;
        end
        if (cmd.build) begin
          older_r   <= newer_r;
          newer_r   <= built;
          emitted_r <= emitted_inc;
        end
      end
      // Hold the result until it is taken
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      sh_r <= in_word;
    end
    if (cmd.extract) begin
      sh_r        <= sh_r << k;
      code_sign_r <= full[bw_eff[5:0]];
      code_mag_r  <= full & mag_mask;
    end
    if (cmd.emit_raw) begin
      out_value_r <= in_word;
      out_last_r  <= 1'b1;
      out_done_r  <= raw_done;
    end
    if (cmd.emit_seed) begin
      out_value_r <= seed_v;
      out_last_r  <= 1'b1;
      out_done_r  <= coded_done;
    end
    if (cmd.build) begin
      out_value_r <= built;
      out_last_r  <= build_last;
      out_done_r  <= coded_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_last_in_item = out_last_r;
  assign out_tile_done    = out_done_r;

  // A code is only cut once all of its bits are at hand
  a_extract_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.extract |-> (rem_r >= k))
    else $error("code extracted before enough bits were available");

  // The open code never holds a whole code
  a_partial_short: assert property (@(posedge clk) disable iff (!rst_n)
    !raw_mode |-> (pbits_r <= bw_eff))
    else $error("open code reached full length");

  // A coded tile never yields more values than its count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !raw_mode |-> (emitted_r <= value_count_r))
    else $error("more values emitted than the tile holds");

  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load_out)
    else $error("result register loaded while stalled");

endmodule

`default_nettype wire

// ----- rtl/double_delta_decoder_core.sv -----
`default_nettype none

// Double-delta decoder for one integer column tile. Software writes bit_width,
// value_count and value_type (index 0, 1, 2) while the block is idle; each write
// starts a new tile. Send the two seed values as mode 0 transactions, then the
// packed code words as mode 1 transactions, codes read MSB first across words.
// A seed or a raw-mode word (bit_width at least the element width minus one)
// is taken and emitted straight from idle. A code word is cut into codes: each
// value goes through a code extraction shifter step and then a rebuild adder
// step, which waits while the result register is full, and the block holds off
// the next transaction until the word is used up. Items after the tile is
// complete are dropped without results.
module double_delta_decoder_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ddd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ddd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_mode,
  input  wire logic [63:0]                     in_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [63:0]                          out_value,
  output logic                                 out_last_in_item,
  output logic                                 out_tile_done
);
  import ddd_pkg::*;

  ddd_cmd_t  cmd;
  ddd_stat_t stat;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  ddd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_word          (in_word),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_last_in_item (out_last_in_item),
    .out_tile_done    (out_tile_done)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ddd_pkg::*;

  // Item modes
  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_CODE = 1'b1;

  // Element type codes
  localparam logic [2:0] VT_INT8   = 3'd0;
  localparam logic [2:0] VT_UINT8  = 3'd1;
  localparam logic [2:0] VT_INT16  = 3'd2;
  localparam logic [2:0] VT_UINT16 = 3'd3;
  localparam logic [2:0] VT_INT32  = 3'd4;
  localparam logic [2:0] VT_UINT32 = 3'd5;
  localparam logic [2:0] VT_INT64  = 3'd6;
  localparam logic [2:0] VT_UINT64 = 3'd7;

  // Index past the last register: write is dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int ITEM_TARGET   = 210;

  typedef struct packed {
    logic [63:0] value;
    logic        last_in_item;
    logic        tile_done;
  } rebuilt_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    logic                 mode;
    logic [63:0]          word;
    logic                 typed;
    rebuilt_t             want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = MODE_SEED;
  logic [63:0]           in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [63:0]           out_value;
  logic                  out_last_in_item;
  logic                  out_tile_done;

  double_delta_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_word          (in_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_last_in_item (out_last_in_item),
    .out_tile_done    (out_tile_done)
  );

  // Decoder shadow: registers and tile state
  logic [6:0]  p_bw;
  logic [31:0] p_count;
  logic [2:0]  p_type;
  logic [63:0] p_older, p_newer, p_code;
  logic [6:0]  p_nbits;
  logic        p_sign;
  logic [31:0] p_emitted;

  rebuilt_t fresh_q[$];
  rebuilt_t expect_q[$];
  step_t    plan[$];

  int errors = 0;
  int values_checked = 0;
  int items_sent = 0;
  int tiles = 0;
  int quiet = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  logic paused_once = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int elem_bits();
    case (p_type[2:1])
      TW_8:    return 8;
      TW_16:   return 16;
      TW_32:   return 32;
      default: return 64;
    endcase
  endfunction

  // Truncate to the element width, then sign- or zero-extend
  function automatic logic [63:0] fit_to_type(input logic [63:0] v);
    int w;
    logic [63:0] mask, r;
    w = elem_bits();
    if (w == 64) return v;
    mask = (64'd1 << w) - 64'd1;
    r = v & mask;
    if (!p_type[0] && r[w-1]) r = r | ~mask;
    return r;
  endfunction

  function automatic void clear_tile();
    p_older = '0;
    p_newer = '0;
    p_code = '0;
    p_nbits = '0;
    p_sign = 1'b0;
    p_emitted = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_BIT_WIDTH:   p_bw = data[6:0];
      CFG_VALUE_COUNT: p_count = data;
      CFG_VALUE_TYPE:  p_type = data[2:0];
      default:         return;
    endcase
    clear_tile();
  endfunction

  // Work out the values one accepted transaction rebuilds, into fresh_q
  function automatic void decode_item(input logic mode, input logic [63:0] word);
    logic [63:0] need, r, dd;
    int bw;
    rebuilt_t tail;
    fresh_q.delete();
    // raw tile: words pass through until the byte count is covered
    if (int'(p_bw) >= elem_bits() - 1) begin
      need = ({32'd0, p_count} * 64'(elem_bits() / 8) + 64'd7) / 64'd8;
      if ({32'd0, p_emitted} >= need) return;
      p_emitted++;
      fresh_q.push_back('{value: word, last_in_item: 1'b1,
                          tile_done: ({32'd0, p_emitted} == need)});
      return;
    end
    if (p_emitted >= p_count) return;
    if (mode == MODE_SEED) begin
      if (p_emitted >= 32'd2) return;
      r = fit_to_type(word);
      p_older = p_newer;
      p_newer = r;
      p_emitted++;
      fresh_q.push_back('{value: r, last_in_item: 1'b1, tile_done: (p_emitted == p_count)});
      return;
    end
    if (p_emitted < 32'd2) return;
    bw = (p_bw == 0) ? 1 : int'(p_bw);
    // walk bits MSB first; codes may straddle transactions
    for (int b = 63; b >= 0 && p_emitted < p_count; b--) begin
      if (p_nbits == 0) begin
        p_sign = word[b];
        p_code = '0;
        p_nbits = 7'd1;
      end else begin
        p_code = {p_code[62:0], word[b]};
        p_nbits++;
      end
      if (int'(p_nbits) == bw + 1) begin
        dd = p_sign ? (64'd0 - p_code) : p_code;
        r = fit_to_type(dd + (p_newer << 1) - p_older);
        p_older = p_newer;
        p_newer = r;
        p_emitted++;
        p_nbits = '0;
        p_code = '0;
        p_sign = 1'b0;
        fresh_q.push_back('{value: r, last_in_item: 1'b0, tile_done: (p_emitted == p_count)});
      end
    end
    // drop the open code once the tile is complete
    if (p_emitted >= p_count) begin
      p_nbits = '0;
      p_code = '0;
      p_sign = 1'b0;
    end
    if (fresh_q.size() > 0) begin
      tail = fresh_q.pop_back();
      tail.last_in_item = 1'b1;
      fresh_q.push_back(tail);
    end
  endfunction

  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t in_row(input logic mode, input logic [63:0] word);
    step_t s;
    s = '0;
    s.mode = mode;
    s.word = word;
    return s;
  endfunction

  function automatic step_t chk_row(input logic mode, input logic [63:0] word,
                                    input logic [63:0] value, input logic last,
                                    input logic done);
    step_t s;
    s = in_row(mode, word);
    s.typed = 1'b1;
    s.want = '{value: value, last_in_item: last, tile_done: done};
    return s;
  endfunction

  // Lower valid and hold until every expected value has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  // Drain, then give a word that yields no value time to finish
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one transaction; predict its values once it is accepted
  task automatic send_item(input logic mode, input logic [63:0] word,
                           input logic typed, input rebuilt_t want);
    if (items_sent < 70) begin
      tx_idle_pct = 6;
      rx_idle_pct = 56;
    end else if (items_sent < 140) begin
      tx_idle_pct = 56;
      rx_idle_pct = 6;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    decode_item(mode, word);
    if (typed) expect_q.push_back(want);
    else foreach (fresh_q[i]) expect_q.push_back(fresh_q[i]);
  endtask

  task automatic send_random(input logic mode);
    send_item(mode, {$urandom, $urandom}, 1'b0, '0);
  endtask

  task automatic build_plan();
    // reset settings: int64, one value
    plan.push_back(in_row(MODE_CODE, 64'hA5A5_A5A5_A5A5_A5A5));
    plan.push_back(chk_row(MODE_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                           1'b1, 1'b1));
    plan.push_back(in_row(MODE_SEED, 64'h0));
    // int8, zero width read as one magnitude bit
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_INT8)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd0));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'd5));
    plan.push_back(chk_row(MODE_SEED, 64'h80, 64'hFFFF_FFFF_FFFF_FF80, 1'b1, 1'b0));
    plan.push_back(chk_row(MODE_SEED, 64'hFFFF_FFFF_FFFF_FF7F, 64'h7F, 1'b1, 1'b0));
    plan.push_back(in_row(MODE_SEED, 64'h1));
    plan.push_back(in_row(MODE_CODE, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(in_row(MODE_CODE, 64'h0));
    // uint64 raw tile of three words
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_UINT64)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd63));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'd3));
    plan.push_back(chk_row(MODE_SEED, 64'h0, 64'h0, 1'b1, 1'b0));
    plan.push_back(chk_row(MODE_CODE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                           1'b1, 1'b0));
    plan.push_back(chk_row(MODE_SEED, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
                           1'b1, 1'b1));
    plan.push_back(in_row(MODE_CODE, 64'h1234));
    // uint8 raw: nine bytes need two words
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_UINT8)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd7));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'd9));
    plan.push_back(chk_row(MODE_CODE, 64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF,
                           1'b1, 1'b0));
    plan.push_back(chk_row(MODE_SEED, 64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3210,
                           1'b1, 1'b1));
    // empty tile drops everything
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_INT32)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd5));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'd0));
    plan.push_back(in_row(MODE_SEED, 64'h5));
    // bit width past the element width, uint16 raw
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_UINT16)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd64));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'd4));
    plan.push_back(chk_row(MODE_SEED, 64'hDEAD_BEEF_0000_FFFF, 64'hDEAD_BEEF_0000_FFFF,
                           1'b1, 1'b1));
    // uint32, three-bit codes straddling words; unused index leaves state alone
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_UINT32)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd2));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'd40));
    plan.push_back(chk_row(MODE_SEED, 64'hFFFF_FFFF_0000_0000, 64'h0, 1'b1, 1'b0));
    plan.push_back(chk_row(MODE_SEED, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
                           1'b1, 1'b0));
    plan.push_back(cfg_row(CFG_NO_REG, 32'hFFFF_FFFF));
    plan.push_back(in_row(MODE_CODE, 64'h9249_2492_4924_9249));
    plan.push_back(in_row(MODE_CODE, 64'h6DB6_DB6D_B6DB_6DB6));
    // int16, largest value count
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_INT16)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd14));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'hFFFF_FFFF));
    plan.push_back(chk_row(MODE_SEED, 64'h7FFF, 64'h7FFF, 1'b1, 1'b0));
    plan.push_back(chk_row(MODE_SEED, 64'h8000, 64'hFFFF_FFFF_FFFF_8000, 1'b1, 1'b0));
    plan.push_back(in_row(MODE_CODE, 64'hFFFF_0000_FFFF_0000));
    // int64, widest coded width
    plan.push_back(cfg_row(CFG_VALUE_TYPE, 32'(VT_INT64)));
    plan.push_back(cfg_row(CFG_BIT_WIDTH, 32'd62));
    plan.push_back(cfg_row(CFG_VALUE_COUNT, 32'd4));
    plan.push_back(chk_row(MODE_SEED, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                           1'b1, 1'b0));
    plan.push_back(chk_row(MODE_SEED, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                           1'b1, 1'b0));
    plan.push_back(in_row(MODE_CODE, 64'hFFFF_FFFF_FFFF_FFFE));
    plan.push_back(in_row(MODE_CODE, 64'h0123_4567_89AB_CDEF));
  endtask

  task automatic run_random();
    logic [2:0]  vt;
    int          tb, bw, bw_eff, roll, n_items;
    int unsigned cnt;
    longint      nbits;
    while (items_sent < ITEM_TARGET) begin
      // pick a tile setting, extremes included
      vt = 3'($urandom_range(7));
      tb = 8 << vt[2:1];
      roll = $urandom_range(9);
      if (roll == 0) bw = $urandom_range(127, tb - 1);
      else if (roll == 1) bw = 0;
      else if (roll < 6) bw = $urandom_range(6, 1);
      else bw = $urandom_range(tb - 2, 1);
      roll = $urandom_range(9);
      if (roll == 0) cnt = 0;
      else if (roll == 1) cnt = $urandom_range(2, 1);
      else if (roll == 2) cnt = $urandom;
      else cnt = $urandom_range(40, 3);
      settle();
      write_reg(CFG_VALUE_TYPE, 32'(vt));
      write_reg(CFG_BIT_WIDTH, 32'(bw));
      write_reg(CFG_VALUE_COUNT, cnt);
      if ($urandom_range(7) == 0) write_reg(CFG_NO_REG, $urandom);
      tiles++;
      bw_eff = (bw == 0) ? 1 : bw;
      if (bw >= tb - 1) begin
        // raw tile: enough words plus one that is dropped, capped at seven
        nbits = (longint'(cnt) * (tb / 8) + 7) / 8;
        n_items = (nbits > 6) ? 7 : int'(nbits) + 1;
        for (int k = 0; k < n_items; k++) send_random(1'($urandom_range(1)));
      end else if ($urandom_range(9) < 8) begin
        // well-formed tile: two seeds, then code words, rarely a stray seed
        // late in the run, hold off the result side while the tile streams in
        if (items_sent >= 150 && cnt > 2) hold_req = 1'b1;
        send_random(MODE_SEED);
        send_random(MODE_SEED);
        nbits = (cnt > 2) ? (longint'(cnt) - 2) * (bw_eff + 1) : 0;
        n_items = (nbits > 6 * 64) ? 6 : int'((nbits + 63) / 64) + 1;
        for (int k = 0; k < n_items; k++) begin
          if (!paused_once && items_sent >= 100) begin
            drain();
            paused_once = 1'b1;
          end
          send_random(($urandom_range(19) == 0) ? MODE_SEED : MODE_CODE);
        end
      end else begin
        // noise: random modes in any order
        n_items = $urandom_range(6, 1);
        for (int k = 0; k < n_items; k++) send_random(1'($urandom_range(1)));
      end
    end
  endtask

  // Result side stall: random, with one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Compare each accepted value with the oldest expectation
  always @(posedge clk) begin
    rebuilt_t want;
    if (rst_n && out_valid && !out_stall) begin
      values_checked++;
      if (expect_q.size() == 0) begin
        $error("value: expected none, actual %h", out_value);
        errors++;
      end else begin
        want = expect_q.pop_front();
        if (out_value !== want.value) begin
          $error("value: expected %h, actual %h", want.value, out_value);
          errors++;
        end
        if (out_last_in_item !== want.last_in_item) begin
          $error("last_in_item: expected %b, actual %b", want.last_in_item, out_last_in_item);
          errors++;
        end
        if (out_tile_done !== want.tile_done) begin
          $error("tile_done: expected %b, actual %b", want.tile_done, out_tile_done);
          errors++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no transaction on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    p_bw = BIT_WIDTH_RST;
    p_count = VALUE_COUNT_RST;
    p_type = VALUE_TYPE_RST;
    clear_tile();
    build_plan();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed table
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].mode, plan[i].word, plan[i].typed, plan[i].want);
      end
    end
    run_random();
    settle();
    $display("Checked %0d values from %0d input transactions over %0d random tiles,",
             values_checked, items_sent, tiles);
    $display("covering seeds, straddled codes, raw tiles, all element types and stalls.");
    if (errors == 0 && expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
